### rtl/ignition_relay_sequencer_macros.svh
// Assertion helpers for the ignition relay sequencer.
`ifndef IGNITION_RELAY_SEQUENCER_MACROS_SVH
`define IGNITION_RELAY_SEQUENCER_MACROS_SVH

`ifndef SYNTHESIS
`define IRS_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("irs assertion failed");
`define IRS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("irs assertion failed");
`else
`define IRS_ASSERT(lbl, clk, rstn, prop)
`define IRS_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

### rtl/irs_pkg.sv
package irs_pkg;

  localparam int unsigned IGN_BIT     = 0;
  localparam int unsigned STARTER_BIT = 1;
  localparam int unsigned LIGHT_BIT   = 2;
  localparam int unsigned LOCK_BIT    = 3;

  localparam logic [7:0] WORD_ALL_OFF = 8'h00;

  localparam logic [2:0] REQ_TICK    = 3'd0;
  localparam logic [2:0] REQ_SET_IGN = 3'd1;
  localparam logic [2:0] REQ_CRANK   = 3'd2;
  localparam logic [2:0] REQ_LIGHT   = 3'd3;
  localparam logic [2:0] REQ_LOCK    = 3'd4;
  localparam logic [2:0] REQ_ALL_OFF = 3'd5;
  localparam logic [2:0] REQ_INIT    = 3'd6;

  localparam logic [1:0] ST_OFF   = 2'd0;
  localparam logic [1:0] ST_ACC   = 2'd1;
  localparam logic [1:0] ST_IGN   = 2'd2;
  localparam logic [1:0] ST_CRANK = 2'd3;

  localparam logic [1:0] CFG_RPM_THR = 2'd0;
  localparam logic [1:0] CFG_DWELL   = 2'd1;
  localparam logic [1:0] CFG_TIMEOUT = 2'd2;

  localparam logic [15:0] RPM_THR_RST = 16'd1000;
  localparam logic [15:0] DWELL_RST   = 16'd1000;
  localparam logic [15:0] TIMEOUT_RST = 16'd5000;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [1:0]  ignition_cmd;
    logic        switch_on;
    logic [15:0] engine_rpm;
    logic [31:0] now_ms;
    logic        port_ok;
  } in_item_t;

  typedef struct packed {
    logic [7:0] relay_word;
    logic       port_written;
    logic       forced_off_written;
    logic [1:0] ignition_state;
    logic       crank_pending;
    logic       is_faulted;
    logic       starter_blocked;
    logic       ready_res;
  } out_item_t;

  typedef struct packed {
    logic [15:0] rpm_thr;
    logic [15:0] dwell_ms;
    logic [15:0] timeout_ms;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  ign;
    logic        light;
    logic        lock;
    logic        init_done;
    logic        fault;
    logic        inhibit;
    logic        esc;
    logic        cranking;
    logic        armed;
    logic        dwell_valid;
    logic [31:0] dwell_start;
    logic [31:0] crank_start;
    logic [7:0]  shadow;
  } state_t;

  typedef struct packed {
    state_t     st;
    logic [7:0] o_word;
    logic       o_written;
    logic       o_forced;
  } work_t;

  function automatic work_t write_port(work_t w, logic [7:0] value, logic ok);
    work_t r;
    r = w;
    if (!r.st.init_done) return r;
    r.o_written = 1'b1;
    r.o_word    = value;
    if (ok) begin
      r.st.fault   = 1'b0;
      r.st.esc     = 1'b0;
      r.st.inhibit = 1'b0;
      return r;
    end
    r.st.fault = 1'b1;
    if (value[STARTER_BIT]) begin
      r.st.esc         = 1'b1;
      r.st.inhibit     = 1'b1;
      r.st.shadow      = WORD_ALL_OFF;
      r.o_forced       = 1'b1;
      r.o_word         = WORD_ALL_OFF;
      r.st.ign         = ST_OFF;
      r.st.cranking    = 1'b0;
      r.st.armed       = 1'b0;
      r.st.dwell_valid = 1'b0;
    end
    return r;
  endfunction

  function automatic work_t drive_relays(work_t w, logic ok);
    work_t      r;
    logic [7:0] word;
    r    = w;
    word = WORD_ALL_OFF;
    word[IGN_BIT]     = (r.st.ign != ST_OFF);
    word[STARTER_BIT] = (r.st.ign == ST_CRANK);
    word[LIGHT_BIT]   = r.st.light;
    word[LOCK_BIT]    = r.st.lock;
    r.st.shadow = word;
    return write_port(r, word, ok);
  endfunction

  function automatic work_t set_ignition(work_t w, logic [1:0] st, logic [31:0] now,
                                         logic ok);
    work_t r;
    r = w;
    if (!r.st.init_done || r.st.fault || r.st.ign == st) return r;
    if (st == ST_CRANK && r.st.inhibit) return r;
    if (r.st.ign == ST_OFF && st != ST_OFF) begin
      r.st.dwell_start = now;
      r.st.dwell_valid = 1'b1;
    end else if (st == ST_OFF) begin
      r.st.dwell_valid = 1'b0;
    end
    if (st == ST_CRANK) begin
      r.st.crank_start = now;
      r.st.cranking    = 1'b1;
    end else if (r.st.ign == ST_CRANK) begin
      r.st.cranking = 1'b0;
    end
    if (st == ST_OFF || st == ST_ACC) r.st.armed = 1'b0;
    r.st.ign = st;
    return drive_relays(r, ok);
  endfunction

  function automatic work_t do_tick(work_t w, logic [15:0] rpm, logic [31:0] now,
                                    logic ok, cfg_t cfg);
    work_t       r;
    logic        running;
    logic [31:0] elapsed;
    r       = w;
    running = (rpm >= cfg.rpm_thr);
    if (!r.st.init_done) return r;
    if (r.st.fault) begin
      if (r.st.esc) r.st.shadow = WORD_ALL_OFF;
      return write_port(r, r.st.shadow, ok);
    end
    if (r.st.armed && !r.st.cranking) begin
      if (running) begin
        r.st.armed = 1'b0;
        return set_ignition(r, ST_IGN, now, ok);
      end
      elapsed = now - r.st.dwell_start;
      if (r.st.dwell_valid && elapsed >= {16'h0000, cfg.dwell_ms}) begin
        r.st.armed = 1'b0;
        r = set_ignition(r, ST_CRANK, now, ok);
      end
    end
    if (!r.st.cranking || r.st.ign != ST_CRANK) return r;
    if (running) return set_ignition(r, ST_IGN, now, ok);
    elapsed = now - r.st.crank_start;
    if (elapsed >= {16'h0000, cfg.timeout_ms}) return set_ignition(r, ST_IGN, now, ok);
    return r;
  endfunction

endpackage

### rtl/ignition_relay_sequencer.sv
// Ignition relay sequencer.
// Input channel (in_valid_i / in_ready_o / in_item_i) takes one timestamped event per
// item: tick, set ignition, crank request, light, lock, all off or init.
// Output channel (out_valid_o / out_ready_i / out_item_o) returns exactly one result
// item per event: the relay word, write flags and the status after the event.
// An accepted item is held in the input register, goes through one pass of next-state
// logic and is captured in the result register, from which the receiver takes it.
// Throughput: one item per cycle unless the receiver stalls; the next event is evaluated
// against the state the previous one left, in the same cycle it leaves the input register.
// When the receiver stalls, the result register holds and the input register
// fills; in_ready_o drops only when both are occupied.
// Configuration: cfg_we_i writes register cfg_idx_i (0 RPM threshold, 1 pre-crank
// dwell, 2 crank timeout) with cfg_wdata_i at once; index 3 is ignored.
// Reset (rst_ni low) empties both stages, clears all ignition, lamp, lock and
// fault state and loads the threshold 1000 RPM, dwell 1000 ms, timeout 5000 ms.
module ignition_relay_sequencer (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  irs_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output irs_pkg::out_item_t out_item_o,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [15:0]        cfg_wdata_i
);

`include "ignition_relay_sequencer_macros.svh"

  irs_pkg::cfg_t      cfg_q;
  irs_pkg::state_t    state_q, state_d;
  irs_pkg::in_item_t  item_q;
  logic               item_vld_q;
  irs_pkg::out_item_t out_q, result_d;
  logic               out_vld_q;
  logic               advance;
  logic               in_acc;

  assign advance    = item_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !item_vld_q || advance;
  assign in_acc     = in_valid_i && in_ready_o;

  irs_step u_step (
    .state_i  (state_q),
    .cfg_i    (cfg_q),
    .item_i   (item_q),
    .state_o  (state_d),
    .result_o (result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rpm_thr    <= irs_pkg::RPM_THR_RST;
      cfg_q.dwell_ms   <= irs_pkg::DWELL_RST;
      cfg_q.timeout_ms <= irs_pkg::TIMEOUT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        irs_pkg::CFG_RPM_THR: cfg_q.rpm_thr    <= cfg_wdata_i;
        irs_pkg::CFG_DWELL:   cfg_q.dwell_ms   <= cfg_wdata_i;
        irs_pkg::CFG_TIMEOUT: cfg_q.timeout_ms <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= '0;
      item_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      if (advance) state_q <= state_d;
      if (in_acc) begin
        item_vld_q <= 1'b1;
      end else if (advance) begin
        item_vld_q <= 1'b0;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) item_q <= in_item_i;
    if (advance) out_q <= result_d;
  end

  assign out_valid_o = out_vld_q;
  assign out_item_o  = out_q;

  `IRS_ASSERT(a_inhibit_has_fault, clk_i, rst_ni, state_q.inhibit |-> state_q.fault)
  `IRS_ASSERT(a_fault_needs_init, clk_i, rst_ni, state_q.fault |-> state_q.init_done)
  `IRS_ASSERT(a_crank_flag_matches, clk_i, rst_ni,
              state_q.cranking == (state_q.ign == irs_pkg::ST_CRANK))
  `IRS_ASSERT(a_forced_off_word, clk_i, rst_ni,
              (out_vld_q && out_q.forced_off_written) |->
              (out_q.port_written && out_q.relay_word == irs_pkg::WORD_ALL_OFF &&
               out_q.starter_blocked))
  `IRS_ASSERT_NEXT(a_advance_gives_result, clk_i, rst_ni, advance, out_vld_q)

endmodule

### rtl/irs_step.sv
module irs_step (
  input  irs_pkg::state_t    state_i,
  input  irs_pkg::cfg_t      cfg_i,
  input  irs_pkg::in_item_t  item_i,
  output irs_pkg::state_t    state_o,
  output irs_pkg::out_item_t result_o
);

  irs_pkg::work_t w;

  always_comb begin
    w.st        = state_i;
    w.o_word    = irs_pkg::WORD_ALL_OFF;
    w.o_written = 1'b0;
    w.o_forced  = 1'b0;
    case (item_i.req_type)
      irs_pkg::REQ_TICK: begin
        w = irs_pkg::do_tick(w, item_i.engine_rpm, item_i.now_ms, item_i.port_ok, cfg_i);
      end
      irs_pkg::REQ_SET_IGN: begin
        w = irs_pkg::set_ignition(w, item_i.ignition_cmd, item_i.now_ms, item_i.port_ok);
      end
      irs_pkg::REQ_CRANK: begin
        if (w.st.init_done && !w.st.fault && !w.st.inhibit) begin
          if (w.st.ign == irs_pkg::ST_OFF) begin
            w = irs_pkg::set_ignition(w, irs_pkg::ST_ACC, item_i.now_ms, item_i.port_ok);
          end
          if (!w.st.cranking) w.st.armed = 1'b1;
        end
      end
      irs_pkg::REQ_LIGHT: begin
        if (w.st.init_done && !w.st.fault && w.st.light != item_i.switch_on) begin
          w.st.light = item_i.switch_on;
          w = irs_pkg::drive_relays(w, item_i.port_ok);
        end
      end
      irs_pkg::REQ_LOCK: begin
        if (w.st.init_done && !w.st.fault && w.st.lock != item_i.switch_on) begin
          w.st.lock = item_i.switch_on;
          w = irs_pkg::drive_relays(w, item_i.port_ok);
        end
      end
      irs_pkg::REQ_ALL_OFF: begin
        w.st.ign         = irs_pkg::ST_OFF;
        w.st.light       = 1'b0;
        w.st.cranking    = 1'b0;
        w.st.dwell_valid = 1'b0;
        w.st.armed       = 1'b0;
        if (w.st.init_done) w = irs_pkg::drive_relays(w, item_i.port_ok);
      end
      irs_pkg::REQ_INIT: begin
        w.st.init_done = 1'b0;
        w.st.fault     = 1'b0;
        w.st.inhibit   = 1'b0;
        w.st.esc       = 1'b0;
        w.st.shadow    = irs_pkg::WORD_ALL_OFF;
        w.o_written    = 1'b1;
        w.o_word       = irs_pkg::WORD_ALL_OFF;
        if (item_i.port_ok) begin
          w.st.init_done   = 1'b1;
          w.st.ign         = irs_pkg::ST_OFF;
          w.st.light       = 1'b0;
          w.st.lock        = 1'b0;
          w.st.dwell_valid = 1'b0;
          w.st.armed       = 1'b0;
          w.st.cranking    = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  assign state_o = w.st;

  always_comb begin
    result_o.relay_word         = w.o_written ? w.o_word : w.st.shadow;
    result_o.port_written       = w.o_written;
    result_o.forced_off_written = w.o_forced;
    result_o.ignition_state     = w.st.ign;
    result_o.crank_pending      = w.st.armed;
    result_o.is_faulted         = w.st.fault;
    result_o.starter_blocked    = w.st.inhibit;
    result_o.ready_res          = w.st.init_done;
  end

endmodule

### dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import irs_pkg::*;

  localparam logic [2:0] REQ_UNUSED      = 3'd7;
  localparam int unsigned IDLE_LIMIT     = 4000;
  localparam int unsigned ITEMS_PER_PHASE = 345;
  localparam int unsigned HOLD_CYCLES    = 300;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  in_item_t    in_item_i   = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  out_item_t   out_item_o;
  logic        cfg_we_i    = 1'b0;
  logic [1:0]  cfg_idx_i   = CFG_RPM_THR;
  logic [15:0] cfg_wdata_i = '0;

  ignition_relay_sequencer u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Predicted sequencer state and configuration
  logic [15:0] cfg_rpm_thr = RPM_THR_RST;
  logic [15:0] cfg_dwell   = DWELL_RST;
  logic [15:0] cfg_timeout = TIMEOUT_RST;

  logic [1:0]  trk_ign       = ST_OFF;
  logic        trk_light     = 1'b0;
  logic        trk_lock      = 1'b0;
  logic        trk_init      = 1'b0;
  logic        trk_fault     = 1'b0;
  logic        trk_inhibit   = 1'b0;
  logic        trk_esc       = 1'b0;
  logic        trk_cranking  = 1'b0;
  logic        trk_armed     = 1'b0;
  logic        trk_dwell_vld = 1'b0;
  logic [31:0] trk_dwell_t0  = '0;
  logic [31:0] trk_crank_t0  = '0;
  logic [7:0]  trk_shadow    = WORD_ALL_OFF;

  logic        ev_ok;
  logic [31:0] ev_now;
  logic [7:0]  wr_word;
  logic        wr_issued;
  logic        wr_forced;

  in_item_t    pending_events[$];
  out_item_t   expected_results[$];

  out_item_t   predicted;
  out_item_t   want;
  logic [31:0] gen_now = '0;
  logic        send_burst = 1'b0;
  logic        recv_burst = 1'b0;
  int unsigned send_gap = 0;
  int unsigned recv_gap = 0;
  int unsigned hold_left = 0;
  int unsigned idle_cycles = 0;
  int unsigned items_sent = 0;
  int unsigned results_seen = 0;
  int unsigned writes_seen = 0;
  int unsigned forced_seen = 0;
  int unsigned crank_seen = 0;
  int unsigned errors = 0;

  task automatic port_write(input logic [7:0] value);
    if (trk_init) begin
      wr_issued = 1'b1;
      wr_word   = value;
      if (ev_ok) begin
        trk_fault   = 1'b0;
        trk_esc     = 1'b0;
        trk_inhibit = 1'b0;
      end else begin
        trk_fault = 1'b1;
        // failed write with the starter engaged: everything forced off
        if (value[STARTER_BIT]) begin
          trk_esc       = 1'b1;
          trk_inhibit   = 1'b1;
          trk_shadow    = WORD_ALL_OFF;
          wr_forced     = 1'b1;
          wr_word       = WORD_ALL_OFF;
          trk_ign       = ST_OFF;
          trk_cranking  = 1'b0;
          trk_armed     = 1'b0;
          trk_dwell_vld = 1'b0;
        end
      end
    end
  endtask

  task automatic relay_refresh();
    logic [7:0] word;
    word              = WORD_ALL_OFF;
    word[IGN_BIT]     = (trk_ign != ST_OFF);
    word[STARTER_BIT] = (trk_ign == ST_CRANK);
    word[LIGHT_BIT]   = trk_light;
    word[LOCK_BIT]    = trk_lock;
    trk_shadow        = word;
    port_write(word);
  endtask

  task automatic ign_change(input logic [1:0] st);
    if (trk_init && !trk_fault && trk_ign != st && !(st == ST_CRANK && trk_inhibit)) begin
      if (trk_ign == ST_OFF && st != ST_OFF) begin
        trk_dwell_t0  = ev_now;
        trk_dwell_vld = 1'b1;
      end else if (st == ST_OFF) begin
        trk_dwell_vld = 1'b0;
      end
      if (st == ST_CRANK) begin
        trk_crank_t0 = ev_now;
        trk_cranking = 1'b1;
      end else if (trk_ign == ST_CRANK) begin
        trk_cranking = 1'b0;
      end
      if (st == ST_OFF || st == ST_ACC) trk_armed = 1'b0;
      trk_ign = st;
      relay_refresh();
    end
  endtask

  task automatic engine_tick(input logic [15:0] rpm);
    logic        running;
    logic        settled;
    logic [31:0] held;
    running = (rpm >= cfg_rpm_thr);
    settled = 1'b0;
    if (trk_init) begin
      if (trk_fault) begin
        if (trk_esc) trk_shadow = WORD_ALL_OFF;
        port_write(trk_shadow);
      end else begin
        if (trk_armed && !trk_cranking) begin
          held = ev_now - trk_dwell_t0;
          if (running) begin
            trk_armed = 1'b0;
            ign_change(ST_IGN);
            settled = 1'b0;
            settled = 1'b1;
          end else if (trk_dwell_vld && held >= {16'h0000, cfg_dwell}) begin
            trk_armed = 1'b0;
            ign_change(ST_CRANK);
          end
        end
        if (!settled && trk_cranking && trk_ign == ST_CRANK) begin
          held = ev_now - trk_crank_t0;
          if (running || held >= {16'h0000, cfg_timeout}) ign_change(ST_IGN);
        end
      end
    end
  endtask

  task automatic predict_relay_result(input in_item_t ev, output out_item_t res);
    ev_ok     = ev.port_ok;
    ev_now    = ev.now_ms;
    wr_issued = 1'b0;
    wr_forced = 1'b0;
    wr_word   = WORD_ALL_OFF;
    case (ev.req_type)
      REQ_TICK: engine_tick(ev.engine_rpm);
      REQ_SET_IGN: ign_change(ev.ignition_cmd);
      REQ_CRANK: begin
        if (trk_init && !trk_fault && !trk_inhibit) begin
          if (trk_ign == ST_OFF) ign_change(ST_ACC);
          if (!trk_cranking) trk_armed = 1'b1;
        end
      end
      REQ_LIGHT: begin
        if (trk_init && !trk_fault && trk_light != ev.switch_on) begin
          trk_light = ev.switch_on;
          relay_refresh();
        end
      end
      REQ_LOCK: begin
        if (trk_init && !trk_fault && trk_lock != ev.switch_on) begin
          trk_lock = ev.switch_on;
          relay_refresh();
        end
      end
      REQ_ALL_OFF: begin
        trk_ign       = ST_OFF;
        trk_light     = 1'b0;
        trk_cranking  = 1'b0;
        trk_dwell_vld = 1'b0;
        trk_armed     = 1'b0;
        if (trk_init) relay_refresh();
      end
      REQ_INIT: begin
        trk_init    = 1'b0;
        trk_fault   = 1'b0;
        trk_inhibit = 1'b0;
        trk_esc     = 1'b0;
        trk_shadow  = WORD_ALL_OFF;
        wr_issued   = 1'b1;
        wr_word     = WORD_ALL_OFF;
        if (ev_ok) begin
          trk_init      = 1'b1;
          trk_ign       = ST_OFF;
          trk_light     = 1'b0;
          trk_lock      = 1'b0;
          trk_dwell_vld = 1'b0;
          trk_armed     = 1'b0;
          trk_cranking  = 1'b0;
        end
      end
      default: begin
      end
    endcase
    res.relay_word         = wr_issued ? wr_word : trk_shadow;
    res.port_written       = wr_issued;
    res.forced_off_written = wr_forced;
    res.ignition_state     = trk_ign;
    res.crank_pending      = trk_armed;
    res.is_faulted         = trk_fault;
    res.starter_blocked    = trk_inhibit;
    res.ready_res          = trk_init;
  endtask

  // Stimulus helpers
  task automatic add_event(input logic [2:0] req, input logic [1:0] cmd, input logic sw,
                           input logic [15:0] rpm, input logic [31:0] now, input logic ok);
    in_item_t ev;
    ev.req_type     = req;
    ev.ignition_cmd = cmd;
    ev.switch_on    = sw;
    ev.engine_rpm   = rpm;
    ev.now_ms       = now;
    ev.port_ok      = ok;
    pending_events.push_back(ev);
  endtask

  function automatic logic pick_ok();
    return $urandom_range(0, 99) >= 7;
  endfunction

  function automatic logic [15:0] pick_rpm(input logic spin);
    int unsigned r;
    logic [15:0] v;
    r = $urandom_range(0, 99);
    if (r < 8) v = 16'hFFFF;
    else if (r < 16) v = 16'h0000;
    else if (r < 24) v = 16'($urandom());
    else if (spin || cfg_rpm_thr == 16'h0000) v = 16'($urandom_range(cfg_rpm_thr, 65535));
    else v = 16'($urandom_range(0, cfg_rpm_thr - 16'd1));
    return v;
  endfunction

  task automatic gen_event(input logic [2:0] req, input logic [1:0] cmd, input logic sw,
                           input logic [15:0] rpm);
    int unsigned r;
    int unsigned span;
    r    = $urandom_range(0, 99);
    span = ((cfg_dwell > cfg_timeout) ? cfg_dwell : cfg_timeout) + 50;
    if (r < 2) gen_now = $urandom();
    else if (r < 45) gen_now = gen_now + $urandom_range(0, 20);
    else if (r < 92) gen_now = gen_now + $urandom_range(0, span);
    else gen_now = gen_now + $urandom_range(0, 70000);
    add_event(req, cmd, sw, rpm, gen_now, pick_ok());
  endtask

  task automatic gen_scenario();
    int unsigned kind;
    kind = $urandom_range(0, 99);
    if (kind < 40) begin
      // typical start: arm the crank, then ticks through dwell and cranking
      if ($urandom_range(0, 4) == 0) gen_event(REQ_INIT, 2'($urandom_range(0, 3)), 1'b0, 16'd0);
      if ($urandom_range(0, 2) == 0)
        gen_event(REQ_SET_IGN, 2'($urandom_range(1, 2)), 1'($urandom_range(0, 1)), 16'd0);
      gen_event(REQ_CRANK, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), pick_rpm(1'b0));
      repeat ($urandom_range(2, 10))
        gen_event(REQ_TICK, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                  pick_rpm($urandom_range(0, 5) == 0));
    end else if (kind < 52) begin
      gen_event(REQ_SET_IGN, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), pick_rpm(1'b0));
      repeat ($urandom_range(0, 3))
        gen_event(REQ_TICK, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                  pick_rpm($urandom_range(0, 3) == 0));
    end else if (kind < 66) begin
      gen_event(($urandom_range(0, 1) == 0) ? REQ_LIGHT : REQ_LOCK, 2'($urandom_range(0, 3)),
                1'($urandom_range(0, 1)), pick_rpm(1'b0));
    end else if (kind < 73) begin
      gen_event(REQ_ALL_OFF, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), pick_rpm(1'b0));
    end else if (kind < 80) begin
      gen_event(REQ_INIT, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), pick_rpm(1'b0));
    end else if (kind < 86) begin
      repeat ($urandom_range(1, 3))
        gen_event(REQ_TICK, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), pick_rpm(1'b0));
    end else begin
      add_event(3'($urandom_range(0, 7)), 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                16'($urandom()), $urandom(), 1'($urandom_range(0, 1)));
    end
  endtask

  function automatic int unsigned pick_gap(input logic burst);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (burst || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic check_field(input string name, input logic [7:0] exp_v, input logic [7:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, exp_v, act_v);
      errors++;
    end
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [15:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    case (idx)
      CFG_RPM_THR: cfg_rpm_thr = value;
      CFG_DWELL:   cfg_dwell   = value;
      CFG_TIMEOUT: cfg_timeout = value;
      default: begin
      end
    endcase
  endtask

  task automatic wait_drained();
    while (pending_events.size() != 0 || in_valid_i || expected_results.size() != 0)
      @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // Event driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_item_i  <= '0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        predict_relay_result(in_item_i, predicted);
        expected_results.push_back(predicted);
        items_sent++;
        send_gap = pick_gap(send_burst);
        if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
      end
      if (in_valid_i && !in_ready_o) begin
        in_valid_i <= 1'b1;
      end else if (send_gap > 0) begin
        send_gap--;
        in_valid_i <= 1'b0;
      end else if (pending_events.size() != 0) begin
        in_valid_i <= 1'b1;
        in_item_i  <= pending_events.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Result monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          $error("result item with no expected result pending");
          errors++;
        end else begin
          want = expected_results.pop_front();
          check_field("relay_word", want.relay_word, out_item_o.relay_word);
          check_field("port_written", 8'(want.port_written), 8'(out_item_o.port_written));
          check_field("forced_off_written", 8'(want.forced_off_written),
                      8'(out_item_o.forced_off_written));
          check_field("ignition_state", 8'(want.ignition_state), 8'(out_item_o.ignition_state));
          check_field("crank_pending", 8'(want.crank_pending), 8'(out_item_o.crank_pending));
          check_field("is_faulted", 8'(want.is_faulted), 8'(out_item_o.is_faulted));
          check_field("starter_blocked", 8'(want.starter_blocked),
                      8'(out_item_o.starter_blocked));
          check_field("ready_res", 8'(want.ready_res), 8'(out_item_o.ready_res));
          if (want.port_written) writes_seen++;
          if (want.forced_off_written) forced_seen++;
          if (want.ignition_state == ST_CRANK) crank_seen++;
        end
        // long receiver hold-off so the block backs up into its input
        if (results_seen == 500 || results_seen == 1400) hold_left = HOLD_CYCLES;
        recv_gap = pick_gap(recv_burst);
        if ($urandom_range(0, 39) == 0) recv_burst = !recv_burst;
      end else if (out_ready_i && !recv_burst && $urandom_range(0, 15) == 0) begin
        recv_gap = pick_gap(1'b0);
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin : stimulus
    logic [15:0] thr;
    logic [15:0] dw;
    logic [15:0] tmo;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed sequence at reset configuration
    add_event(REQ_TICK,    ST_OFF,   1'b0, 16'd0,     32'h0000_0000, 1'b1);
    add_event(REQ_SET_IGN, ST_IGN,   1'b1, 16'd0,     32'd10,        1'b1);
    add_event(REQ_LIGHT,   ST_OFF,   1'b1, 16'd0,     32'd20,        1'b1);
    add_event(REQ_ALL_OFF, ST_OFF,   1'b0, 16'd0,     32'd30,        1'b1);
    add_event(REQ_UNUSED,  ST_CRANK, 1'b1, 16'hFFFF,  32'hFFFF_FFFF, 1'b1);
    add_event(REQ_INIT,    ST_OFF,   1'b0, 16'd0,     32'd40,        1'b0);
    add_event(REQ_INIT,    ST_OFF,   1'b0, 16'd0,     32'd60,        1'b1);
    add_event(REQ_LIGHT,   ST_OFF,   1'b1, 16'd0,     32'd70,        1'b1);
    add_event(REQ_LOCK,    ST_OFF,   1'b1, 16'd0,     32'd80,        1'b1);
    add_event(REQ_SET_IGN, ST_ACC,   1'b0, 16'd0,     32'd100,       1'b1);
    add_event(REQ_SET_IGN, ST_IGN,   1'b0, 16'd0,     32'd110,       1'b1);
    add_event(REQ_SET_IGN, ST_CRANK, 1'b0, 16'd0,     32'd120,       1'b1);
    add_event(REQ_TICK,    ST_OFF,   1'b0, 16'd1000,  32'd140,       1'b1);
    add_event(REQ_SET_IGN, ST_OFF,   1'b0, 16'd0,     32'd150,       1'b1);
    // crank from off across the timer wrap: dwell 999 then 1000, then timeout
    add_event(REQ_CRANK,   ST_OFF,   1'b0, 16'd0,     32'hFFFF_FE00, 1'b1);
    add_event(REQ_TICK,    ST_OFF,   1'b0, 16'd0,     32'h0000_01E7, 1'b1);
    add_event(REQ_TICK,    ST_OFF,   1'b0, 16'd0,     32'h0000_01E8, 1'b1);
    add_event(REQ_TICK,    ST_OFF,   1'b0, 16'd999,   32'h0000_1570, 1'b1);
    // starter write fails: escalation, then inhibited crank and recovery
    add_event(REQ_CRANK,   ST_OFF,   1'b0, 16'd0,     32'h0000_1600, 1'b1);
    add_event(REQ_TICK,    ST_OFF,   1'b0, 16'd0,     32'h0000_1610, 1'b0);
    add_event(REQ_CRANK,   ST_OFF,   1'b0, 16'd0,     32'h0000_1620, 1'b1);
    add_event(REQ_TICK,    ST_OFF,   1'b0, 16'd0,     32'h0000_1630, 1'b1);
    add_event(REQ_LIGHT,   ST_OFF,   1'b0, 16'd0,     32'h0000_1640, 1'b0);
    add_event(REQ_ALL_OFF, ST_OFF,   1'b0, 16'd0,     32'h0000_1650, 1'b1);
    add_event(REQ_CRANK,   ST_OFF,   1'b0, 16'd0,     32'h0000_1660, 1'b0);
    add_event(REQ_INIT,    ST_OFF,   1'b0, 16'd0,     32'h0000_1670, 1'b1);
    wait_drained();

    for (int p = 0; p < 5; p++) begin
      case (p)
        0: begin
          thr = RPM_THR_RST; dw = DWELL_RST; tmo = TIMEOUT_RST;
        end
        1: begin
          thr = 16'h0000; dw = 16'h0000; tmo = 16'h0000;
        end
        2: begin
          thr = 16'hFFFF; dw = 16'hFFFF; tmo = 16'hFFFF;
        end
        3: begin
          thr = 16'($urandom_range(500, 4000));
          dw  = 16'($urandom_range(0, 300));
          tmo = 16'($urandom_range(0, 600));
        end
        default: begin
          thr = 16'($urandom()); dw = 16'($urandom()); tmo = 16'($urandom());
        end
      endcase
      cfg_write(CFG_RPM_THR, thr);
      cfg_write(CFG_DWELL, dw);
      cfg_write(CFG_TIMEOUT, tmo);
      @(posedge clk_i);
      cfg_we_i <= 1'b0;
      gen_now = (p % 2 == 1) ? (32'hFFFF_0000 | 32'($urandom_range(0, 65535))) : $urandom();
      while (pending_events.size() < ITEMS_PER_PHASE) gen_scenario();
      wait_drained();
    end

    $display("Run covered %0d events over five threshold/dwell/timeout settings incl. extremes.",
             items_sent);
    $display("Relay writes %0d, forced-off escalations %0d, results while cranking %0d.",
             writes_seen, forced_seen, crank_seen);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
